FILE: rtl/normal_map_blend_pixel_assert.svh
// ----------------------------------------------------------------------------
// Normal-map blend assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NORMAL_MAP_BLEND_PIXEL_ASSERT_SVH
`define NORMAL_MAP_BLEND_PIXEL_ASSERT_SVH

// same-cycle implication
`define NMB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nmb assertion failed");

// next-cycle implication
`define NMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nmb assertion failed");

`endif

FILE: rtl/nmb_pkg.sv
// ----------------------------------------------------------------------------
// nmb_pkg
// Shared widths, codes and payload types of the normal-map blender.
// ----------------------------------------------------------------------------
`default_nettype none

package nmb_pkg;

  localparam int CH_BITS   = 16;
  localparam int GAIN_BITS = 16;
  localparam int FRAC_BITS = 12;
  localparam int N_W       = CH_BITS + 2;
  localparam int GP_W      = N_W + GAIN_BITS + 1;
  localparam int B_W       = GP_W - FRAC_BITS;
  localparam int PROD_W    = N_W + B_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int V_W       = CH_BITS + 8;
  localparam int S_W       = 2 * V_W;
  localparam int SQ_STEPS  = S_W / 2;
  localparam int R_W       = V_W;
  localparam int U_FRAC    = 14;
  localparam int Q_W       = U_FRAC + 1;
  localparam int NUM_W     = V_W + U_FRAC;
  localparam int CFG_W     = 16;

  localparam logic signed [N_W-1:0] N_ONE = N_W'(1) << CH_BITS;
  localparam logic [CH_BITS-1:0] CH_MID = CH_BITS'(1) << (CH_BITS - 1);

  typedef enum logic [2:0] {
    BM_LINEAR     = 3'd0,
    BM_DERIVATIVE = 3'd1,
    BM_UDN        = 3'd2,
    BM_UNITY      = 3'd3,
    BM_WHITEOUT   = 3'd4
  } blend_e;

  typedef enum logic [0:0] {
    CFG_METHOD = 1'b0,
    CFG_SCALE  = 1'b1
  } cfg_idx_e;

  localparam logic [GAIN_BITS-1:0] SCALE_RST = GAIN_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [V_W-1:0] x;
    logic signed [V_W-1:0] y;
    logic signed [V_W-1:0] z;
    logic [CH_BITS-1:0]    alpha;
  } vec_t;

  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/nmb_front.sv
// ----------------------------------------------------------------------------
// nmb_front
// Channel to normal mapping, detail gain and blend; four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module nmb_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         vld_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]  base_red_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]  base_green_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]  base_blue_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]  base_alpha_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]  detail_red_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]  detail_green_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]  detail_blue_i,
  input  wire nmb_pkg::blend_e              method_i,
  input  wire logic [nmb_pkg::GAIN_BITS-1:0] scale_i,
  output logic                              vld_o,
  output nmb_pkg::vec_t                     vec_o
);

  localparam int N_W    = nmb_pkg::N_W;
  localparam int GP_W   = nmb_pkg::GP_W;
  localparam int B_W    = nmb_pkg::B_W;
  localparam int PROD_W = nmb_pkg::PROD_W;
  localparam int SUM_W  = nmb_pkg::SUM_W;
  localparam int V_W    = nmb_pkg::V_W;
  localparam int CH     = nmb_pkg::CH_BITS;
  localparam int FR     = nmb_pkg::FRAC_BITS;
  localparam int GAIN_BITS_P = nmb_pkg::GAIN_BITS;

  function automatic logic signed [B_W-1:0] gdiv(input logic signed [GP_W-1:0] p);
    logic signed [GP_W-1:0] t;
    t = p[GP_W-1] ? p + GP_W'((1 << FR) - 1) : p;
    return $signed(t[GP_W-1:FR]);
  endfunction

  function automatic logic signed [V_W-1:0] vdiv(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    t = s[SUM_W-1] ? s + SUM_W'((1 << CH) - 1) : s;
    return $signed(t[CH +: V_W]);
  endfunction

  // stage 1
  logic                    v1_q;
  logic signed [N_W-1:0]   ax1_q, ay1_q, az1_q;
  logic signed [GP_W-1:0]  px1_q, py1_q, pz1_q;
  logic [CH-1:0]           al1_q;
  logic signed [N_W-1:0]   dx, dy, dz;
  logic signed [GAIN_BITS_P:0] gain;

  assign dx   = $signed({1'b0, detail_red_i, 1'b0}) - nmb_pkg::N_ONE;
  assign dy   = $signed({1'b0, detail_green_i, 1'b0}) - nmb_pkg::N_ONE;
  assign dz   = $signed({1'b0, detail_blue_i, 1'b0}) - nmb_pkg::N_ONE;
  assign gain = $signed({1'b0, scale_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q <= $signed({1'b0, base_red_i, 1'b0}) - nmb_pkg::N_ONE;
      ay1_q <= $signed({1'b0, base_green_i, 1'b0}) - nmb_pkg::N_ONE;
      az1_q <= $signed({1'b0, base_blue_i, 1'b0}) - nmb_pkg::N_ONE;
      px1_q <= GP_W'(dx) * GP_W'(gain);
      py1_q <= GP_W'(dy) * GP_W'(gain);
      pz1_q <= GP_W'(dz) * GP_W'(gain);
      al1_q <= base_alpha_i;
    end
  end

  // stage 2
  logic                  v2_q;
  logic signed [N_W-1:0] ax2_q, ay2_q, az2_q;
  logic signed [B_W-1:0] bx2_q, by2_q, bz2_q;
  logic [CH-1:0]         al2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
      az2_q <= az1_q;
      bx2_q <= gdiv(px1_q);
      by2_q <= gdiv(py1_q);
      bz2_q <= gdiv(pz1_q);
      al2_q <= al1_q;
    end
  end

  // stage 3
  logic                     v3_q;
  logic signed [V_W-1:0]    lx3_q, ly3_q;
  logic signed [N_W-1:0]    az3_q;
  logic signed [B_W-1:0]    bz3_q;
  logic signed [PROD_W-1:0] axbz_q, bxaz_q, aybz_q, byaz_q, azbz_q;
  logic signed [PROD_W-1:0] byax_q, bzax_q, bxay_q, bzay_q, bxax_q, byay_q;
  logic [CH-1:0]            al3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lx3_q  <= V_W'(ax2_q) + V_W'(bx2_q);
      ly3_q  <= V_W'(ay2_q) + V_W'(by2_q);
      az3_q  <= az2_q;
      bz3_q  <= bz2_q;
      axbz_q <= PROD_W'(ax2_q) * PROD_W'(bz2_q);
      bxaz_q <= PROD_W'(bx2_q) * PROD_W'(az2_q);
      aybz_q <= PROD_W'(ay2_q) * PROD_W'(bz2_q);
      byaz_q <= PROD_W'(by2_q) * PROD_W'(az2_q);
      azbz_q <= PROD_W'(az2_q) * PROD_W'(bz2_q);
      byax_q <= PROD_W'(by2_q) * PROD_W'(ax2_q);
      bzax_q <= PROD_W'(bz2_q) * PROD_W'(ax2_q);
      bxay_q <= PROD_W'(bx2_q) * PROD_W'(ay2_q);
      bzay_q <= PROD_W'(bz2_q) * PROD_W'(ay2_q);
      bxax_q <= PROD_W'(bx2_q) * PROD_W'(ax2_q);
      byay_q <= PROD_W'(by2_q) * PROD_W'(ay2_q);
      al3_q  <= al2_q;
    end
  end

  // stage 4: blend select
  logic                  v4_q;
  nmb_pkg::vec_t         vec4_q;
  logic signed [V_W-1:0] vx, vy, vz, wz;

  assign wz = vdiv(SUM_W'(azbz_q));

  always_comb begin
    unique case (method_i)
      nmb_pkg::BM_LINEAR: begin
        vx = lx3_q;
        vy = ly3_q;
        vz = V_W'(az3_q) + V_W'(bz3_q);
      end
      nmb_pkg::BM_DERIVATIVE: begin
        vx = vdiv(SUM_W'(axbz_q) + SUM_W'(bxaz_q));
        vy = vdiv(SUM_W'(aybz_q) + SUM_W'(byaz_q));
        vz = wz;
      end
      nmb_pkg::BM_UDN: begin
        vx = lx3_q;
        vy = ly3_q;
        vz = V_W'(az3_q);
      end
      nmb_pkg::BM_UNITY: begin
        vx = vdiv(SUM_W'(bxaz_q) + SUM_W'(byax_q) + SUM_W'(bzax_q));
        vy = vdiv(SUM_W'(bxay_q) + SUM_W'(byaz_q) + SUM_W'(bzay_q));
        vz = vdiv(SUM_W'(azbz_q) - SUM_W'(bxax_q) - SUM_W'(byay_q));
      end
      default: begin
        vx = lx3_q;
        vy = ly3_q;
        vz = wz;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec4_q.x     <= vx;
      vec4_q.y     <= vy;
      vec4_q.z     <= vz;
      vec4_q.alpha <= al3_q;
    end
  end

  assign vld_o = v4_q;
  assign vec_o = vec4_q;

endmodule

`default_nettype wire

FILE: rtl/nmb_sqrt.sv
// ----------------------------------------------------------------------------
// nmb_sqrt
// Squared length and pipelined integer square root, one result bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module nmb_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      vld_i,
  input  wire nmb_pkg::vec_t             vec_i,
  output nmb_pkg::ctl_t                  ctl_o,
  output nmb_pkg::vec_t                  vec_o,
  output logic [nmb_pkg::R_W-1:0]        root_o
);

  localparam int S_W   = nmb_pkg::S_W;
  localparam int STEPS = nmb_pkg::SQ_STEPS;

  // squares
  logic          va_q;
  nmb_pkg::vec_t veca_q;
  logic [S_W-1:0] sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      veca_q <= vec_i;
      sx_q   <= S_W'(S_W'(vec_i.x) * S_W'(vec_i.x));
      sy_q   <= S_W'(S_W'(vec_i.y) * S_W'(vec_i.y));
      sz_q   <= S_W'(S_W'(vec_i.z) * S_W'(vec_i.z));
    end
  end

  // root stages; index 0 holds the sum
  nmb_pkg::ctl_t  ctl_q [0:STEPS];
  nmb_pkg::vec_t  vec_q [0:STEPS];
  logic [S_W-1:0] rem_q [0:STEPS];
  logic [S_W-1:0] res_q [0:STEPS];

  logic [S_W-1:0] ssum;
  assign ssum = sx_q + sy_q + sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_q[0].vld  <= va_q;
      ctl_q[0].zero <= (ssum == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q[0] <= veca_q;
      rem_q[0] <= ssum;
      res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [S_W-1:0] BIT = S_W'(1) << (2 * (STEPS - 1 - k));
    logic [S_W-1:0] trial;
    assign trial = res_q[k] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '0;
      end else if (en_i) begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vec_q[k+1] <= vec_q[k];
        if (rem_q[k] >= trial) begin
          rem_q[k+1] <= rem_q[k] - trial;
          res_q[k+1] <= (res_q[k] >> 1) + BIT;
        end else begin
          rem_q[k+1] <= rem_q[k];
          res_q[k+1] <= res_q[k] >> 1;
        end
      end
    end
  end

  assign ctl_o  = ctl_q[STEPS];
  assign vec_o  = vec_q[STEPS];
  assign root_o = res_q[STEPS][nmb_pkg::R_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/nmb_div.sv
// ----------------------------------------------------------------------------
// nmb_div
// Pipelined restoring division of each |component| by the length, to Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module nmb_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire nmb_pkg::ctl_t              ctl_i,
  input  wire nmb_pkg::vec_t              vec_i,
  input  wire logic [nmb_pkg::R_W-1:0]    root_i,
  output nmb_pkg::ctl_t                   ctl_o,
  output logic [2:0]                      neg_o,
  output logic [nmb_pkg::Q_W-1:0]         quo_o [3],
  output logic [nmb_pkg::CH_BITS-1:0]     alpha_o
);

  localparam int Q_W   = nmb_pkg::Q_W;
  localparam int NUM_W = nmb_pkg::NUM_W;
  localparam int V_W   = nmb_pkg::V_W;
  localparam int R_W   = nmb_pkg::R_W;

  nmb_pkg::ctl_t        ctl_q [0:Q_W];
  logic [2:0]           neg_q [0:Q_W];
  logic [R_W-1:0]       dsr_q [0:Q_W];
  logic [nmb_pkg::CH_BITS-1:0] al_q [0:Q_W];
  logic [NUM_W-1:0]     rem_q [0:Q_W][3];
  logic [Q_W-1:0]       quo_q [0:Q_W][3];

  logic signed [V_W-1:0] comp [3];
  assign comp[0] = vec_i.x;
  assign comp[1] = vec_i.y;
  assign comp[2] = vec_i.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dsr_q[0] <= root_i;
      al_q[0]  <= vec_i.alpha;
      for (int c = 0; c < 3; c++) begin
        neg_q[0][c] <= comp[c][V_W-1];
        rem_q[0][c] <= NUM_W'(comp[c][V_W-1] ? V_W'(-comp[c]) : V_W'(comp[c]))
                       << nmb_pkg::U_FRAC;
        quo_q[0][c] <= '0;
      end
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int SH = Q_W - 1 - k;
    logic [NUM_W-1:0] dsh;
    assign dsh = NUM_W'(dsr_q[k]) << SH;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '0;
      end else if (en_i) begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k+1] <= neg_q[k];
        dsr_q[k+1] <= dsr_q[k];
        al_q[k+1]  <= al_q[k];
        for (int c = 0; c < 3; c++) begin
          if (rem_q[k][c] >= dsh) begin
            rem_q[k+1][c] <= rem_q[k][c] - dsh;
            quo_q[k+1][c] <= quo_q[k][c] | (Q_W'(1) << SH);
          end else begin
            rem_q[k+1][c] <= rem_q[k][c];
            quo_q[k+1][c] <= quo_q[k][c];
          end
        end
      end
    end
  end

  assign ctl_o   = ctl_q[Q_W];
  assign neg_o   = neg_q[Q_W];
  assign alpha_o = al_q[Q_W];
  assign quo_o[0] = quo_q[Q_W][0];
  assign quo_o[1] = quo_q[Q_W][1];
  assign quo_o[2] = quo_q[Q_W][2];

endmodule

`default_nettype wire

FILE: rtl/normal_map_blend_pixel.sv
// ----------------------------------------------------------------------------
// normal_map_blend_pixel
// Blends a base and a detail normal-map pixel and renormalises the result.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o carries one pixel per transaction
// (base RGB + alpha, detail RGB). Output channel: out_valid_o/out_ready_i
// carries the blended RGB and the base alpha.
// Configuration: cfg_we_i writes blend method (index 0) or detail gain
// (index 1, Q4.12) at once; write only while no pixel is in flight.
// The result passes the front stages, the 24-stage square root and the
// 15-stage divider, one result bit per stage, and the output register.
// Throughput: one pixel per cycle unless stalled; every stage is registered.
// A stalled receiver freezes the whole pipeline and in_ready_o drops;
// the held result stays on the output port, nothing is lost or repeated.
// Reset empties the pipeline and sets whiteout blending and unity gain.
// ----------------------------------------------------------------------------
`default_nettype none

module normal_map_blend_pixel (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [0:0]                      cfg_idx_i,
  input  wire logic [nmb_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [nmb_pkg::CH_BITS-1:0]     base_red_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]     base_green_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]     base_blue_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]     base_alpha_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]     detail_red_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]     detail_green_i,
  input  wire logic [nmb_pkg::CH_BITS-1:0]     detail_blue_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [nmb_pkg::CH_BITS-1:0]          out_red_o,
  output logic [nmb_pkg::CH_BITS-1:0]          out_green_o,
  output logic [nmb_pkg::CH_BITS-1:0]          out_blue_o,
  output logic [nmb_pkg::CH_BITS-1:0]          out_alpha_o
);

  localparam int CH  = nmb_pkg::CH_BITS;
  localparam int Q_W = nmb_pkg::Q_W;
  localparam int U_W = Q_W + 1;
  localparam int O_W = CH + Q_W + 1;
  localparam logic signed [U_W-1:0] U_ONE = U_W'(1) << nmb_pkg::U_FRAC;
  localparam logic [CH-1:0] MID = nmb_pkg::CH_MID;

  nmb_pkg::blend_e               method_q;
  logic [nmb_pkg::GAIN_BITS-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= nmb_pkg::BM_WHITEOUT;
      scale_q  <= nmb_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (nmb_pkg::cfg_idx_e'(cfg_idx_i))
        nmb_pkg::CFG_METHOD: method_q <= nmb_pkg::blend_e'(cfg_wdata_i[2:0]);
        nmb_pkg::CFG_SCALE:  scale_q  <= cfg_wdata_i[nmb_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  logic          f_vld;
  nmb_pkg::vec_t f_vec;

  nmb_front u_front (
    .clk_i,
    .rst_ni,
    .en_i          (en),
    .vld_i         (in_valid_i),
    .base_red_i,
    .base_green_i,
    .base_blue_i,
    .base_alpha_i,
    .detail_red_i,
    .detail_green_i,
    .detail_blue_i,
    .method_i      (method_q),
    .scale_i       (scale_q),
    .vld_o         (f_vld),
    .vec_o         (f_vec)
  );

  nmb_pkg::ctl_t           s_ctl;
  nmb_pkg::vec_t           s_vec;
  logic [nmb_pkg::R_W-1:0] s_root;

  nmb_sqrt u_sqrt (
    .clk_i,
    .rst_ni,
    .en_i   (en),
    .vld_i  (f_vld),
    .vec_i  (f_vec),
    .ctl_o  (s_ctl),
    .vec_o  (s_vec),
    .root_o (s_root)
  );

  nmb_pkg::ctl_t   d_ctl;
  logic [2:0]      d_neg;
  logic [Q_W-1:0]  d_quo [3];
  logic [CH-1:0]   d_alpha;

  nmb_div u_div (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .ctl_i   (s_ctl),
    .vec_i   (s_vec),
    .root_i  (s_root),
    .ctl_o   (d_ctl),
    .neg_o   (d_neg),
    .quo_o   (d_quo),
    .alpha_o (d_alpha)
  );

  // Q2.14 to channel with clamp and saturation
  logic [CH-1:0] chan [3];

  always_comb begin
    logic signed [U_W-1:0] u;
    logic [O_W-1:0]        o;
    for (int c = 0; c < 3; c++) begin
      u = d_neg[c] ? -$signed({1'b0, d_quo[c]}) : $signed({1'b0, d_quo[c]});
      if (u > U_ONE) u = U_ONE;
      if (u < -U_ONE) u = -U_ONE;
      o = (O_W'(u + U_ONE) << CH) >> (nmb_pkg::U_FRAC + 1);
      if (d_ctl.zero) begin
        chan[c] = nmb_pkg::CH_MID;
      end else if (o > O_W'({CH{1'b1}})) begin
        chan[c] = '1;
      end else begin
        chan[c] = o[CH-1:0];
      end
    end
  end

  logic [CH-1:0] red_q, green_q, blue_q, alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_ctl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= chan[0];
      green_q <= chan[1];
      blue_q  <= chan[2];
      alpha_q <= d_alpha;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_alpha_o = alpha_q;

`include "normal_map_blend_pixel_assert.svh"

  `NMB_ASSERT_NOW(a_stall_only_on_full, !in_ready_o, out_valid_o && !out_ready_i)
  `NMB_ASSERT_NEXT(a_zero_mid, en && d_ctl.vld && d_ctl.zero, out_valid_o && out_red_o == MID)
  `NMB_ASSERT_NEXT(a_stall_freeze, !en, $stable(d_ctl))

endmodule

`default_nettype wire
